FILE: rtl/bqlp_pkg.sv
// shared types and constants for the polyphonic biquad low-pass core
package bqlp_pkg;

  localparam int DEF_VOICES      = 16;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int VOICE_BITS      = 4;
  localparam int COEF_BITS       = 25;
  localparam int FRAC_BITS       = 22;
  localparam int CFG_INDEX_BITS  = 4;
  localparam int OUT_FIFO_DEPTH  = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_COEF_B0 = 4'd0,
    REG_COEF_B1 = 4'd1,
    REG_COEF_A1 = 4'd2,
    REG_COEF_A2 = 4'd3
  } cfg_reg_e;

  // per-item control that travels with each pipeline stage
  typedef struct packed {
    logic                  valid;
    logic                  active;
    logic [VOICE_BITS-1:0] voice;
    logic                  last;
  } tag_t;

endpackage

FILE: rtl/bqlp_in_if.sv
// input sample channel: voice, sample and block marker
interface bqlp_in_if import bqlp_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic [VOICE_BITS-1:0]         voice;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_last;

  modport source (output valid, voice, sample_in, block_last, input ready);
  modport sink   (input valid, voice, sample_in, block_last, output ready);
endinterface

FILE: rtl/bqlp_out_if.sv
// filtered sample channel: voice echo, result and block marker
interface bqlp_out_if import bqlp_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic [VOICE_BITS-1:0]         voice_out;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          block_last_out;

  modport source (output valid, voice_out, sample_out, block_last_out, input ready);
  modport sink   (input valid, voice_out, sample_out, block_last_out, output ready);
endinterface

FILE: rtl/bqlp_ram.sv
// generic single-port-write, registered-read RAM
module bqlp_ram #(
  parameter int  WIDTH     = 8,
  parameter int  DEPTH     = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/bqlp_mac.sv
// multiply and accumulate stages: five products, partial sums, round and saturate
module bqlp_mac import bqlp_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [COEF_BITS-1:0]   coef_b0,
  input  logic signed [COEF_BITS-1:0]   coef_b1,
  input  logic signed [COEF_BITS-1:0]   coef_a1,
  input  logic signed [COEF_BITS-1:0]   coef_a2,
  input  tag_t                          s1_tag,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] x1,
  input  logic signed [SAMPLE_BITS-1:0] x2,
  input  logic signed [SAMPLE_BITS-1:0] y1,
  input  logic signed [SAMPLE_BITS-1:0] y2,
  output tag_t                          s2_tag,
  output tag_t                          s3_tag,
  output logic signed [SAMPLE_BITS-1:0] s3_x,
  output logic signed [SAMPLE_BITS-1:0] s3_x1,
  output logic signed [SAMPLE_BITS-1:0] s3_y1,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
  localparam int FF_BITS   = PROD_BITS + 2;
  localparam int FB_BITS   = PROD_BITS + 1;
  localparam int ACC_BITS  = PROD_BITS + 3;
  localparam int Q_BITS    = ACC_BITS - FRAC_BITS;
  localparam logic signed [ACC_BITS-1:0] RND = ACC_BITS'(2 ** (FRAC_BITS - 1));

  logic signed [PROD_BITS-1:0]   p_x, p_x1, p_x2, p_y1, p_y2;
  logic signed [SAMPLE_BITS-1:0] s2_x, s2_x1, s2_y1;
  logic signed [FF_BITS-1:0]     sum_ff;
  logic signed [FB_BITS-1:0]     sum_fb;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [Q_BITS-1:0]      q;
  logic                          sat_hi, sat_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
      s3_tag <= '0;
    end else begin
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    p_x   <= coef_b0 * x;
    p_x1  <= coef_b1 * x1;
    p_x2  <= coef_b0 * x2;
    p_y1  <= coef_a1 * y1;
    p_y2  <= coef_a2 * y2;
    s2_x  <= x;
    s2_x1 <= x1;
    s2_y1 <= y1;
  end

  // stage 3: feed-forward and feedback partial sums
  always_ff @(posedge clk) begin
    sum_ff <= FF_BITS'(p_x) + FF_BITS'(p_x1) + FF_BITS'(p_x2);
    sum_fb <= FB_BITS'(p_y1) + FB_BITS'(p_y2);
    s3_x   <= s2_x;
    s3_x1  <= s2_x1;
    s3_y1  <= s2_y1;
  end

  // round half up, floor shift, saturate
  always_comb begin
    acc    = ACC_BITS'(sum_ff) - ACC_BITS'(sum_fb) + RND;
    q      = acc[ACC_BITS-1:FRAC_BITS];
    sat_hi = !q[Q_BITS-1] && (|q[Q_BITS-2:SAMPLE_BITS-1]);
    sat_lo = q[Q_BITS-1] && !(&q[Q_BITS-2:SAMPLE_BITS-1]);
    if (sat_hi) begin
      y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (sat_lo) begin
      y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y = q[SAMPLE_BITS-1:0];
    end
  end

endmodule

FILE: rtl/bqlp_out_fifo.sv
// small result queue between the pipeline and the output channel
module bqlp_out_fifo #(
  parameter int  WIDTH    = 8,
  parameter int  DEPTH    = 8,
  localparam int PTR_BITS = $clog2(DEPTH),
  localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic                valid,
  output logic [WIDTH-1:0]    data,
  output logic [CNT_BITS-1:0] count
);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count_next;
  logic                pop_ok;

  assign valid  = (count != '0);
  assign data   = mem[rd_ptr];
  assign pop_ok = pop && valid;

  always_comb begin
    unique case ({push, pop_ok})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/polyphonic_biquad_lowpass_core.sv
// polyphonic direct form I low-pass biquad, per-voice delay state held in one RAM
// a sample passes the state-read, product and partial-sum registers, then the result queue
// throughput: one sample per cycle while the result queue has room and no voice repeats
//   within three consecutive samples; a repeated voice waits until its earlier sample
//   has left the multiply stage, so the same voice back to back stalls (feedback through y1)
// reset: synchronous, clears coefficients, pipeline, result queue and per-voice written flags,
//   so every voice starts from zero state with no clearing pass
module polyphonic_biquad_lowpass_core import bqlp_pkg::*; #(
  parameter int VOICES      = DEF_VOICES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]      cfg_data,
  bqlp_in_if.sink                   feed,
  bqlp_out_if.source                result
);

  localparam int ADDR_BITS  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ENTRY_BITS = 4 * SAMPLE_BITS;
  localparam int OUT_BITS   = VOICE_BITS + SAMPLE_BITS + 1;
  localparam int CNT_BITS   = $clog2(OUT_FIFO_DEPTH + 1);

  // coefficient registers
  logic signed [COEF_BITS-1:0] coef_b0, coef_b1, coef_a1, coef_a2;

  // input side
  logic                 accept;
  logic                 feed_active;
  logic [ADDR_BITS-1:0] feed_addr;
  logic                 hazard;
  logic                 room;
  logic [CNT_BITS:0]    pending;

  // stage 1: state read from ram
  tag_t                          s1_tag, s1_tag_next;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic [ADDR_BITS-1:0]          s1_addr;
  logic [ENTRY_BITS-1:0]         ram_rdata;
  logic [ENTRY_BITS-1:0]         entry;
  logic signed [SAMPLE_BITS-1:0] x1, x2, y1, y2;

  // later stages from the mac
  tag_t                          s2_tag, s3_tag;
  logic signed [SAMPLE_BITS-1:0] s3_x, s3_x1, s3_y1, s3_y;
  logic signed [SAMPLE_BITS-1:0] res_sample;

  // write-back and forwarding
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;
  logic                  wb_valid;
  logic [ADDR_BITS-1:0]  wb_addr;
  logic [ENTRY_BITS-1:0] wb_data;
  logic [VOICES-1:0]     voice_written;

  // output queue
  logic                fifo_valid;
  logic [OUT_BITS-1:0] fifo_data;
  logic [CNT_BITS-1:0] fifo_count;

  // coefficient writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_B0: coef_b0 <= cfg_data;
        REG_COEF_B1: coef_b1 <= cfg_data;
        REG_COEF_A1: coef_a1 <= cfg_data;
        REG_COEF_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // voices at or above VOICES pass through with a zero result and touch no state
  assign feed_addr   = ADDR_BITS'(feed.voice);
  assign feed_active = (32'(feed.voice) < VOICES);

  // interlock: a voice still in the state-read or multiply stage has not written back its y yet
  assign hazard = (s1_tag.valid && s1_tag.active && (s1_tag.voice == feed.voice)) ||
                  (s2_tag.valid && s2_tag.active && (s2_tag.voice == feed.voice));

  // credit check: every sample in flight must find a slot in the result queue
  assign pending = {1'b0, fifo_count} + (CNT_BITS+1)'(s1_tag.valid)
                 + (CNT_BITS+1)'(s2_tag.valid) + (CNT_BITS+1)'(s3_tag.valid);
  assign room    = (pending < (CNT_BITS+1)'(OUT_FIFO_DEPTH));

  assign feed.ready = room && !hazard;
  assign accept     = feed.valid && feed.ready;

  assign s1_tag_next = '{valid: accept, active: feed_active, voice: feed.voice,
                         last: feed.block_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
    end else begin
      s1_tag <= s1_tag_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_x    <= feed.sample_in;
    s1_addr <= feed_addr;
  end

  // per-voice state entry: {x1, x2, y1, y2}
  bqlp_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (VOICES)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (feed_addr),
    .rdata (ram_rdata)
  );

  // a write at the same edge as the read is not seen by the ram, take it from wb;
  // a voice never written reads as zero state
  always_comb begin
    if (wb_valid && (wb_addr == s1_addr)) begin
      entry = wb_data;
    end else if (voice_written[s1_addr]) begin
      entry = ram_rdata;
    end else begin
      entry = '0;
    end
    x1 = entry[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
    x2 = entry[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    y1 = entry[2*SAMPLE_BITS-1:SAMPLE_BITS];
    y2 = entry[SAMPLE_BITS-1:0];
  end

  bqlp_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .coef_b0 (coef_b0),
    .coef_b1 (coef_b1),
    .coef_a1 (coef_a1),
    .coef_a2 (coef_a2),
    .s1_tag  (s1_tag),
    .x       (s1_x),
    .x1      (x1),
    .x2      (x2),
    .y1      (y1),
    .y2      (y2),
    .s2_tag  (s2_tag),
    .s3_tag  (s3_tag),
    .s3_x    (s3_x),
    .s3_x1   (s3_x1),
    .s3_y1   (s3_y1),
    .y       (s3_y)
  );

  // write-back: shift the delay line of this voice
  assign wr_en   = s3_tag.valid && s3_tag.active;
  assign wr_addr = ADDR_BITS'(s3_tag.voice);
  assign wr_data = {s3_x, s3_x1, s3_y, s3_y1};

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid      <= 1'b0;
      voice_written <= '0;
    end else begin
      wb_valid <= wr_en;
      if (wr_en) begin
        voice_written[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= wr_addr;
    wb_data <= wr_data;
  end

  assign res_sample = s3_tag.active ? s3_y : '0;

  // result queue decouples the pipeline from output stalls
  bqlp_out_fifo #(
    .WIDTH (OUT_BITS),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_tag.valid),
    .push_data ({s3_tag.voice, res_sample, s3_tag.last}),
    .pop       (result.ready),
    .valid     (fifo_valid),
    .data      (fifo_data),
    .count     (fifo_count)
  );

  // output transfer
  assign result.valid          = fifo_valid;
  assign result.voice_out      = fifo_data[OUT_BITS-1:SAMPLE_BITS+1];
  assign result.sample_out     = fifo_data[SAMPLE_BITS:1];
  assign result.block_last_out = fifo_data[0];

endmodule
